[src/fpr_pkg.sv]
// shared types and constants for the four-bit pixel run decoder
// used by fpr_ctrl, fpr_dp and the top level; depends on nothing
package fpr_pkg;

  // decode phases of the command parser
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_NIB   = 4'd1;
  localparam logic [3:0] PH_SW1   = 4'd2;
  localparam logic [3:0] PH_SHORT = 4'd3;
  localparam logic [3:0] PH_SW2   = 4'd4;
  localparam logic [3:0] PH_LEN4  = 4'd5;
  localparam logic [3:0] PH_SW3   = 4'd6;
  localparam logic [3:0] PH_LEN9  = 4'd7;
  localparam logic [3:0] PH_LEN25 = 4'd8;
  localparam logic [3:0] PH_COL   = 4'd9;

  // one decoded run waiting to be sent
  typedef struct packed {
    logic [8:0] run_length;
    logic [3:0] pixel_color;
    logic       string_end;
  } run_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // take a new word
    logic step;  // consume one bit
    logic pop;   // move one result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       done;      // this step finishes the word
    logic [1:0] remain;    // results of this word not yet sent
    logic       out_free;  // output register can take a result
  } status_t;

endpackage

[src/fpr_ctrl.sv]
// controller state machine for the four-bit pixel run decoder
// depends on fpr_pkg (command and status structs)
module fpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fpr_pkg::status_t status_i,
  output fpr_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BITS  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BITS;
        end
      end
      S_BITS: begin
        cmd_o.step = 1'b1;
        if (status_i.done) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status_i.remain == 2'd0) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.pop = 1'b1;
          if (status_i.remain == 2'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/fpr_dp.sv]
// datapath of the four-bit pixel run decoder: bit shifter, command parser,
// per-word result buffer and output register; depends on fpr_pkg
module fpr_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpr_pkg::cmd_t    cmd_i,
  output fpr_pkg::status_t status_o,
  input  logic [7:0]       code_byte_i,
  input  logic             segment_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [8:0]       run_length_o,
  output logic [3:0]       pixel_color_o,
  output logic             string_end_o,
  output logic             truncated_o,
  output logic             last_of_byte_o
);

  // decoder state
  logic [3:0] phase_q, phase_d;
  logic [7:0] field_q, field_d;
  logic [3:0] bits_left_q, bits_left_d;
  logic [8:0] pend_q, pend_d;

  // word being consumed
  logic [7:0] shift_q;
  logic       seg_q;
  logic [2:0] bit_cnt_q;

  // results of the current word
  fpr_pkg::run_t buf_q [2];
  logic [1:0]    buf_cnt_q;
  logic [1:0]    rd_q;
  logic          trunc_q;

  logic          out_valid_q;

  // one-bit step
  logic [3:0]    ph;
  logic [3:0]    bl;
  logic [7:0]    fv;
  logic          res_v;
  fpr_pkg::run_t res;
  logic          done;

  always_comb begin
    ph = phase_q;
    bl = bits_left_q;
    fv = field_q;
    if (ph == fpr_pkg::PH_IDLE || ph > fpr_pkg::PH_COL || bl == 4'd0 || bl > 4'd8) begin
      ph = fpr_pkg::PH_NIB;
      bl = 4'd4;
      fv = '0;
    end
    fv = {fv[6:0], shift_q[7]};
    bl = bl - 4'd1;

    phase_d     = ph;
    bits_left_d = bl;
    field_d     = fv;
    pend_d      = pend_q;
    res_v       = 1'b0;
    res         = '0;

    if (bl == 4'd0) begin
      field_d     = '0;
      bits_left_d = 4'd0;
      phase_d     = fpr_pkg::PH_IDLE;
      unique case (ph)
        fpr_pkg::PH_NIB: begin
          if (fv[3:0] != 4'd0) begin
            res_v           = 1'b1;
            res.run_length  = 9'd1;
            res.pixel_color = fv[3:0];
          end else begin
            phase_d     = fpr_pkg::PH_SW1;
            bits_left_d = 4'd1;
          end
        end
        fpr_pkg::PH_SW1: begin
          if (fv[0] == 1'b0) begin
            phase_d     = fpr_pkg::PH_SHORT;
            bits_left_d = 4'd3;
          end else begin
            phase_d     = fpr_pkg::PH_SW2;
            bits_left_d = 4'd1;
          end
        end
        fpr_pkg::PH_SHORT: begin
          res_v = 1'b1;
          if (fv[2:0] == 3'd0) begin
            res.string_end = 1'b1;
          end else begin
            res.run_length = {6'd0, fv[2:0]} + 9'd2;
          end
        end
        fpr_pkg::PH_SW2: begin
          if (fv[0] == 1'b0) begin
            phase_d     = fpr_pkg::PH_LEN4;
            bits_left_d = 4'd2;
          end else begin
            phase_d     = fpr_pkg::PH_SW3;
            bits_left_d = 4'd2;
          end
        end
        fpr_pkg::PH_LEN4: begin
          pend_d      = {7'd0, fv[1:0]} + 9'd4;
          phase_d     = fpr_pkg::PH_COL;
          bits_left_d = 4'd4;
        end
        fpr_pkg::PH_SW3: begin
          case (fv[1:0])
            2'd0: begin
              res_v          = 1'b1;
              res.run_length = 9'd1;
            end
            2'd1: begin
              res_v          = 1'b1;
              res.run_length = 9'd2;
            end
            2'd2: begin
              phase_d     = fpr_pkg::PH_LEN9;
              bits_left_d = 4'd4;
            end
            default: begin
              phase_d     = fpr_pkg::PH_LEN25;
              bits_left_d = 4'd8;
            end
          endcase
        end
        fpr_pkg::PH_LEN9: begin
          pend_d      = {5'd0, fv[3:0]} + 9'd9;
          phase_d     = fpr_pkg::PH_COL;
          bits_left_d = 4'd4;
        end
        fpr_pkg::PH_LEN25: begin
          pend_d      = {1'b0, fv} + 9'd25;
          phase_d     = fpr_pkg::PH_COL;
          bits_left_d = 4'd4;
        end
        default: begin
          res_v           = 1'b1;
          res.run_length  = pend_q;
          res.pixel_color = fv[3:0];
          pend_d          = '0;
        end
      endcase
    end
  end

  // end of string drops the rest of the word
  assign done = (bit_cnt_q == 3'd7) || (res_v && res.string_end);

  assign status_o.done     = done;
  assign status_o.remain   = buf_cnt_q - rd_q + {1'b0, trunc_q};
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // decoder state and buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fpr_pkg::PH_IDLE;
      field_q     <= '0;
      bits_left_q <= '0;
      pend_q      <= '0;
      bit_cnt_q   <= '0;
      buf_cnt_q   <= '0;
      rd_q        <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        bit_cnt_q <= '0;
        buf_cnt_q <= '0;
        rd_q      <= '0;
        trunc_q   <= 1'b0;
      end
      if (cmd_i.step) begin
        bit_cnt_q <= bit_cnt_q + 3'd1;
        if (res_v) begin
          buf_cnt_q <= buf_cnt_q + 2'd1;
        end
        if (done && seg_q) begin
          // segment limit: flag an open command and start clean
          trunc_q     <= (phase_d != fpr_pkg::PH_IDLE);
          phase_q     <= fpr_pkg::PH_IDLE;
          field_q     <= '0;
          bits_left_q <= '0;
          pend_q      <= '0;
        end else begin
          phase_q     <= phase_d;
          field_q     <= field_d;
          bits_left_q <= bits_left_d;
          pend_q      <= pend_d;
        end
      end
      if (cmd_i.pop) begin
        if (rd_q < buf_cnt_q) begin
          rd_q <= rd_q + 2'd1;
        end else begin
          trunc_q <= 1'b0;
        end
      end
      if (cmd_i.pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      shift_q <= code_byte_i;
      seg_q   <= segment_end_i;
    end
    if (cmd_i.step) begin
      shift_q <= {shift_q[6:0], 1'b0};
      if (res_v) begin
        buf_q[buf_cnt_q[0]] <= res;
      end
    end
    if (cmd_i.pop) begin
      last_of_byte_o <= (status_o.remain == 2'd1);
      if (rd_q < buf_cnt_q) begin
        run_length_o  <= buf_q[rd_q[0]].run_length;
        pixel_color_o <= buf_q[rd_q[0]].pixel_color;
        string_end_o  <= buf_q[rd_q[0]].string_end;
        truncated_o   <= 1'b0;
      end else begin
        run_length_o  <= '0;
        pixel_color_o <= '0;
        string_end_o  <= 1'b0;
        truncated_o   <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> status_o.remain != 2'd0)
    else $error("pop with no result left");

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_cnt_q <= 2'd2 && rd_q <= buf_cnt_q)
    else $error("result buffer pointers out of range");

  a_end_xor_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(string_end_o && truncated_o))
    else $error("end of string and truncation on one result");

  a_end_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (string_end_o || truncated_o)) |-> run_length_o == 9'd0)
    else $error("marker result with nonzero length");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (bit_cnt_q == 3'd0 && buf_cnt_q == 2'd0 && !trunc_q))
    else $error("word load did not clear bit and result counters");
`endif

endmodule

[src/four_bit_pixel_run_decoder.sv]
// top level of the four-bit pixel run decoder
// depends on fpr_pkg, fpr_ctrl and fpr_dp
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  code_byte_i, segment_end_i
//   out      out_valid_o/out_ready_i run_length_o, pixel_color_o, string_end_o,
//                                    truncated_o, last_of_byte_o
//
// a word is loaded, then steps one bit per cycle through the command parser until
// its last bit or an end of string, then moves each of its results to the output
// register when the output is free; a word with no result still passes S_FLUSH
// the next word is taken while the last result still waits in the output register
// reset (rst_ni low) returns the parser to the start of a command
// a stalled output holds the result buffer flush; nothing is dropped
module four_bit_pixel_run_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] code_byte_i,
  input  logic       segment_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [8:0] run_length_o,
  output logic [3:0] pixel_color_o,
  output logic       string_end_o,
  output logic       truncated_o,
  output logic       last_of_byte_o
);

  fpr_pkg::cmd_t    cmd;
  fpr_pkg::status_t status;

  fpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .code_byte_i    (code_byte_i),
    .segment_end_i  (segment_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .run_length_o   (run_length_o),
    .pixel_color_o  (pixel_color_o),
    .string_end_o   (string_end_o),
    .truncated_o    (truncated_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule

[verif/testbench.sv]
// self-checking testbench for four_bit_pixel_run_decoder
// builds code strings from pixel commands and predicts each run bit by bit
// depends on fpr_pkg and the decoder top level
module testbench;

  typedef struct packed {
    logic [8:0] run_length;
    logic [3:0] pixel_color;
    logic       string_end;
    logic       truncated;
    logic       last_of_byte;
  } run_word_t;

  typedef enum int {
    CMD_PIXEL, CMD_SHORT_ZERO, CMD_EOS, CMD_RUN4, CMD_ONE_ZERO, CMD_TWO_ZERO, CMD_RUN9, CMD_RUN25
  } cmd_kind_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] code_byte_i;
  logic       segment_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [8:0] run_length_o;
  logic [3:0] pixel_color_o;
  logic       string_end_o;
  logic       truncated_o;
  logic       last_of_byte_o;

  // predicted decoder state
  logic [3:0] phase_q;
  logic [7:0] field_q;
  logic [3:0] bits_to_go_q;
  logic [8:0] pend_len_q;

  run_word_t  pending_runs[$];
  run_word_t  want_run;
  logic       code_bits[$];
  int         errors;
  int         items_sent;
  int         stall_len;
  logic       src_idle_on;
  logic       sink_idle_on;

  four_bit_pixel_run_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_byte_i    (code_byte_i),
    .segment_end_i  (segment_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .run_length_o   (run_length_o),
    .pixel_color_o  (pixel_color_o),
    .string_end_o   (string_end_o),
    .truncated_o    (truncated_o),
    .last_of_byte_o (last_of_byte_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    begin
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
    end
  endtask

  function automatic run_word_t mk_run(input logic [8:0] len, input logic [3:0] col,
                                       input logic eos, input logic trunc);
    run_word_t r;
    begin
      r.run_length   = len;
      r.pixel_color  = col;
      r.string_end   = eos;
      r.truncated    = trunc;
      r.last_of_byte = 1'b0;
      return r;
    end
  endfunction

  task automatic go_phase(input logic [3:0] ph, input logic [3:0] nbits);
    begin
      phase_q      = ph;
      bits_to_go_q = nbits;
      field_q      = '0;
    end
  endtask

  task automatic clear_decoder;
    begin
      go_phase(fpr_pkg::PH_IDLE, 4'd0);
      pend_len_q = '0;
    end
  endtask

  // walks the word bit by bit and queues the runs it completes and any truncation run
  task automatic predict_runs(input logic [7:0] b, input logic seg);
    run_word_t  res[3];
    int         n;
    int         i;
    int         k;
    logic       ended;
    logic [7:0] v;
    begin
      n = 0;
      ended = 1'b0;
      for (i = 7; i >= 0 && n < 3 && !ended; i--) begin
        if (phase_q == fpr_pkg::PH_IDLE || phase_q > fpr_pkg::PH_COL ||
            bits_to_go_q == 0 || bits_to_go_q > 8)
          go_phase(fpr_pkg::PH_NIB, 4'd4);
        field_q      = {field_q[6:0], b[i]};
        bits_to_go_q = bits_to_go_q - 4'd1;
        if (bits_to_go_q == 0) begin
          v = field_q;
          case (phase_q)
            fpr_pkg::PH_NIB: begin
              if (v != 0) begin
                res[n++] = mk_run(9'd1, v[3:0], 1'b0, 1'b0);
                go_phase(fpr_pkg::PH_IDLE, 4'd0);
              end else begin
                go_phase(fpr_pkg::PH_SW1, 4'd1);
              end
            end
            fpr_pkg::PH_SW1: begin
              if (v == 0) go_phase(fpr_pkg::PH_SHORT, 4'd3);
              else go_phase(fpr_pkg::PH_SW2, 4'd1);
            end
            fpr_pkg::PH_SHORT: begin
              go_phase(fpr_pkg::PH_IDLE, 4'd0);
              if (v == 0) begin
                res[n++] = mk_run(9'd0, 4'd0, 1'b1, 1'b0);
                ended = 1'b1;
              end else begin
                res[n++] = mk_run(9'(v) + 9'd2, 4'd0, 1'b0, 1'b0);
              end
            end
            fpr_pkg::PH_SW2: begin
              if (v == 0) go_phase(fpr_pkg::PH_LEN4, 4'd2);
              else go_phase(fpr_pkg::PH_SW3, 4'd2);
            end
            fpr_pkg::PH_LEN4: begin
              pend_len_q = 9'(v) + 9'd4;
              go_phase(fpr_pkg::PH_COL, 4'd4);
            end
            fpr_pkg::PH_SW3: begin
              if (v == 0) begin
                res[n++] = mk_run(9'd1, 4'd0, 1'b0, 1'b0);
                go_phase(fpr_pkg::PH_IDLE, 4'd0);
              end else if (v == 1) begin
                res[n++] = mk_run(9'd2, 4'd0, 1'b0, 1'b0);
                go_phase(fpr_pkg::PH_IDLE, 4'd0);
              end else if (v == 2) begin
                go_phase(fpr_pkg::PH_LEN9, 4'd4);
              end else begin
                go_phase(fpr_pkg::PH_LEN25, 4'd8);
              end
            end
            fpr_pkg::PH_LEN9: begin
              pend_len_q = 9'(v) + 9'd9;
              go_phase(fpr_pkg::PH_COL, 4'd4);
            end
            fpr_pkg::PH_LEN25: begin
              pend_len_q = 9'(v) + 9'd25;
              go_phase(fpr_pkg::PH_COL, 4'd4);
            end
            default: begin
              res[n++] = mk_run(pend_len_q, v[3:0], 1'b0, 1'b0);
              pend_len_q = '0;
              go_phase(fpr_pkg::PH_IDLE, 4'd0);
            end
          endcase
        end
      end
      // segment end inside an open command gives a truncation run
      if (seg && phase_q != fpr_pkg::PH_IDLE && n < 3) begin
        res[n++] = mk_run(9'd0, 4'd0, 1'b0, 1'b1);
        clear_decoder();
      end else if (seg) begin
        clear_decoder();
      end
      if (n > 0) res[n-1].last_of_byte = 1'b1;
      for (k = 0; k < n; k++) pending_runs.push_back(res[k]);
    end
  endtask

  // offers one word, holding it until taken
  task automatic send_word(input logic [7:0] b, input logic seg);
    begin
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      code_byte_i   <= b;
      segment_end_i <= seg;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      predict_runs(b, seg);
      items_sent++;
    end
  endtask

  task automatic push_bits(input int value, input int nbits);
    int i;
    begin
      for (i = nbits - 1; i >= 0; i--) code_bits.push_back(value[i]);
    end
  endtask

  task automatic pad_to_byte;
    begin
      while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic add_cmd(input cmd_kind_e kind, input int len, input int col);
    begin
      case (kind)
        CMD_PIXEL:      push_bits(col, 4);
        CMD_SHORT_ZERO: push_bits(len - 2, 8);
        CMD_EOS: begin
          push_bits(0, 8);
          // the rest of the word is dropped after end of string
          pad_to_byte();
        end
        CMD_RUN4: begin
          push_bits(8'h08 | (len - 4), 8);
          push_bits(col, 4);
        end
        CMD_ONE_ZERO:   push_bits(8'h0C, 8);
        CMD_TWO_ZERO:   push_bits(8'h0D, 8);
        CMD_RUN9: begin
          push_bits(8'h0E, 8);
          push_bits(len - 9, 4);
          push_bits(col, 4);
        end
        default: begin
          push_bits(8'h0F, 8);
          push_bits(len - 25, 8);
          push_bits(col, 4);
        end
      endcase
    end
  endtask

  task automatic add_random_cmd;
    cmd_kind_e kind;
    begin
      kind = cmd_kind_e'($urandom_range(0, 7));
      if (kind == CMD_EOS && $urandom_range(0, 2) != 0) kind = CMD_PIXEL;
      case (kind)
        CMD_PIXEL:      add_cmd(kind, 1, $urandom_range(1, 15));
        CMD_SHORT_ZERO: add_cmd(kind, $urandom_range(3, 9), 0);
        CMD_RUN4:       add_cmd(kind, $urandom_range(4, 7), $urandom_range(0, 15));
        CMD_RUN9:       add_cmd(kind, $urandom_range(9, 24), $urandom_range(0, 15));
        CMD_RUN25:      add_cmd(kind, $urandom_range(25, 280), $urandom_range(0, 15));
        default:        add_cmd(kind, 0, 0);
      endcase
    end
  endtask

  // sends the built bit string as words, with segment end on the last one when seg is set
  task automatic send_bits(input logic seg);
    logic [7:0] b;
    int         i;
    begin
      pad_to_byte();
      while (code_bits.size() != 0) begin
        for (i = 7; i >= 0; i--) b[i] = code_bits.pop_front();
        send_word(b, seg && code_bits.size() == 0);
      end
    end
  endtask

  task automatic send_random_string;
    int   ncmd;
    int   start;
    int   cut;
    logic seg;
    begin
      ncmd = $urandom_range(1, 6);
      repeat (ncmd) add_random_cmd();
      if ($urandom_range(0, 4) == 0) begin
        // chop the tail of one more command and end the segment there
        start = code_bits.size();
        add_random_cmd();
        cut = $urandom_range(1, code_bits.size() - start - 1);
        repeat (cut) void'(code_bits.pop_back());
        seg = 1'b1;
      end else begin
        seg = 1'($urandom_range(0, 1));
      end
      send_bits(seg);
    end
  endtask

  task automatic send_noise;
    begin
      repeat ($urandom_range(1, 3))
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_each_command;
    begin
      add_cmd(CMD_PIXEL, 1, 1);
      add_cmd(CMD_PIXEL, 1, 15);
      add_cmd(CMD_SHORT_ZERO, 3, 0);
      add_cmd(CMD_SHORT_ZERO, 9, 0);
      add_cmd(CMD_RUN4, 4, 0);
      add_cmd(CMD_RUN4, 7, 15);
      add_cmd(CMD_ONE_ZERO, 0, 0);
      add_cmd(CMD_TWO_ZERO, 0, 0);
      add_cmd(CMD_RUN9, 9, 3);
      add_cmd(CMD_RUN9, 24, 15);
      add_cmd(CMD_RUN25, 25, 0);
      add_cmd(CMD_RUN25, 280, 15);
      add_cmd(CMD_EOS, 0, 0);
      send_bits(1'b0);
    end
  endtask

  task automatic test_segment_end_cases;
    begin
      send_word(8'h00, 1'b1);  // end of string right at segment end
      send_word(8'h1F, 1'b1);  // two runs, command closes at segment end
      send_word(8'h10, 1'b1);  // one run then truncation
      send_word(8'h0E, 1'b0);  // word that finishes nothing
      send_word(8'hA5, 1'b0);
      send_word(8'h0F, 1'b1);  // truncated inside a long run length
    end
  endtask

  task automatic test_random_strings(input int stop_at);
    begin
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_random_string();
      end
    end
  endtask

  task automatic test_output_backpressure;
    int n;
    begin
      stall_len = 400;
      n = items_sent + 30;
      while (items_sent < n) send_random_string();
    end
  endtask

  // sink side: random hold-offs and one long stall on request
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
        stall_len = 0;
        out_ready_i <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("unexpected run", run_length_o, 0);
      end else begin
        want_run = pending_runs.pop_front();
        if (run_length_o !== want_run.run_length)
          report_mismatch("run_length", run_length_o, want_run.run_length);
        if (pixel_color_o !== want_run.pixel_color)
          report_mismatch("pixel_color", pixel_color_o, want_run.pixel_color);
        if (string_end_o !== want_run.string_end)
          report_mismatch("string_end", string_end_o, want_run.string_end);
        if (truncated_o !== want_run.truncated)
          report_mismatch("truncated", truncated_o, want_run.truncated);
        if (last_of_byte_o !== want_run.last_of_byte)
          report_mismatch("last_of_byte", last_of_byte_o, want_run.last_of_byte);
      end
    end
  end

  initial begin
    int waited;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    code_byte_i   = '0;
    segment_end_i = 1'b0;
    errors        = 0;
    items_sent    = 0;
    stall_len     = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    clear_decoder();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_command();
    test_segment_end_cases();
    test_random_strings(130);
    test_output_backpressure();
    test_random_strings(220);
    // no idling on either side for the last stretch
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_strings(260);
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_runs.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_runs.size() != 0)
      report_mismatch("runs never delivered", 0, pending_runs.size());
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
